@@ src/weighted_frequency_error_estimator_top_macros.svh @@
// Assertion macros for the weighted frequency error estimator.
// Included by the top level; no other dependencies.
`ifndef WEIGHTED_FREQUENCY_ERROR_ESTIMATOR_TOP_MACROS_SVH
`define WEIGHTED_FREQUENCY_ERROR_ESTIMATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WFEE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define WFEE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ src/wfee_pkg.sv @@
// Shared types and constants for the weighted frequency error estimator.
// No dependencies.
package wfee_pkg;

	localparam int ACC_W      = 64;
	localparam int CNT_W      = 16;
	localparam int ERR_W      = 24;
	localparam int IC_W       = 16;
	localparam int W_W        = 2 * IC_W;
	localparam int PROD_W     = ERR_W + W_W + 1;
	localparam int DIV_CNT_W  = $clog2(ACC_W);
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic OP_OBSERVE = 1'b0;
	localparam logic OP_CLEAR   = 1'b1;

	localparam logic MODE_ENDPOINT = 1'b0;
	localparam logic MODE_WEIGHTED = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_MODE          = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVALS = 1'b1;

	localparam logic [IC_W-1:0]  MIN_INTERVALS_RST = 16'd4;
	localparam logic [CNT_W-1:0] CNT_MAX           = '1;
	localparam logic [ERR_W-1:0] EST_POS_SAT       = 24'h7FFFFF;
	localparam logic [ERR_W-1:0] EST_NEG_SAT       = 24'h800000;

	typedef struct packed {
		logic                    opcode;
		logic [IC_W-1:0]         span_count;
		logic signed [ERR_W-1:0] error_ppb;
		logic                    window_done;
	} in_item_t;

	typedef struct packed {
		logic signed [ERR_W-1:0] estimate_ppb;
		logic [CNT_W-1:0]        observations;
	} out_item_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

@@ src/wfee_div.sv @@
// Unsigned 64-bit restoring divider, one quotient bit per cycle.
// Depends on wfee_pkg.
module wfee_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [wfee_pkg::ACC_W-1:0]   dividend,
	input  logic [wfee_pkg::ACC_W-1:0]   divisor,
	output wfee_pkg::div_stat_t          stat,
	output logic [wfee_pkg::ACC_W-1:0]   quotient
);
	import wfee_pkg::*;

	logic [ACC_W-1:0]     rem_q;
	logic [ACC_W-1:0]     quo_q;
	logic [ACC_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [ACC_W:0]       trial;
	logic                 ge;

	// trial subtract of the shifted partial remainder
	assign trial = {rem_q, quo_q[ACC_W-1]} - {1'b0, dvs_q};
	assign ge    = !trial[ACC_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(ACC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? trial[ACC_W-1:0] : {rem_q[ACC_W-2:0], quo_q[ACC_W-1]};
			quo_q <= {quo_q[ACC_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

@@ src/weighted_frequency_error_estimator_top.sv @@
// Clear items and endpoint items without a result end at decode; an endpoint result goes
// straight to the output register, a weighted result through the bit-serial divider.
// Throughput: one item at a time; in_stall is high from acceptance until the item
// is finished, also while the output is stalled.
// Reset (arst_n low, asynchronous): accumulators and count zero, mode endpoint,
// min_intervals 4, no result pending. Depends on wfee_pkg, wfee_div and the macros header.
`include "weighted_frequency_error_estimator_top_macros.svh"

module weighted_frequency_error_estimator_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// observation items
	input  logic                                in_valid,
	output logic                                in_stall,
	input  wfee_pkg::in_item_t                  in_item,
	// estimate items
	output logic                                out_valid,
	input  logic                                out_stall,
	output wfee_pkg::out_item_t                 out_item,
	// register writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [wfee_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wfee_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import wfee_pkg::*;

	// Sequencer: decode, square, scale, accumulate, take magnitude, add the
	// rounding half, divide, then hand the result to the output register.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DEC  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_ACC  = 3'd3;
	localparam logic [2:0] ST_CHK  = 3'd4;
	localparam logic [2:0] ST_RND  = 3'd5;
	localparam logic [2:0] ST_DIV  = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	logic [2:0]         state_q;

	// configuration
	logic               mode_q;
	logic [IC_W-1:0]    min_intervals_q;

	// estimator state
	logic [ACC_W-1:0]   wacc_q;
	logic [ACC_W-1:0]   weight_q;
	logic [CNT_W-1:0]   obs_count_q;

	// captured item and working registers
	in_item_t           item_q;
	logic [W_W-1:0]     w_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [ACC_W-1:0]   mag_q;
	logic               neg_q;
	out_item_t          res_q;
	out_item_t          out_q;
	logic               out_valid_q;

	// divider
	logic               div_start;
	logic [ACC_W-1:0]   div_quo;
	div_stat_t          div_stat;

	logic               in_acc;
	logic               out_load;
	logic               q_big;
	logic               q_sat;
	logic [ERR_W-1:0]   est;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = (state_q == ST_IDLE);
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || !out_stall);
	assign div_start = (state_q == ST_RND);

	wfee_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag_q + (weight_q >> 1)),
		.divisor  (weight_q),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	// Saturate the quotient magnitude to the 24-bit range, then apply the sign.
	assign q_big = |div_quo[ACC_W-1:ERR_W];
	assign q_sat = neg_q ? (q_big || (div_quo[ERR_W-1] && |div_quo[ERR_W-2:0]))
	                     : (q_big || div_quo[ERR_W-1]);
	always_comb begin
		if (neg_q) begin
			est = q_sat ? EST_NEG_SAT : -div_quo[ERR_W-1:0];
		end else begin
			est = q_sat ? EST_POS_SAT : div_quo[ERR_W-1:0];
		end
	end

	// control and estimator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			mode_q          <= MODE_ENDPOINT;
			min_intervals_q <= MIN_INTERVALS_RST;
			wacc_q          <= '0;
			weight_q        <= '0;
			obs_count_q     <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_MODE:          mode_q          <= cfg_data[0];
					REG_MIN_INTERVALS: min_intervals_q <= cfg_data[IC_W-1:0];
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					if (item_q.opcode == OP_CLEAR) begin
						wacc_q      <= '0;
						weight_q    <= '0;
						obs_count_q <= '0;
						state_q     <= ST_IDLE;
					end else if (mode_q == MODE_ENDPOINT) begin
						if (item_q.window_done) begin
							obs_count_q <= CNT_W'(1);
							state_q     <= ST_OUT;
						end else begin
							state_q <= ST_IDLE;
						end
					end else if (item_q.span_count >= min_intervals_q) begin
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_CHK;
					end
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					wacc_q   <= wacc_q + ACC_W'(prod_q);
					weight_q <= weight_q + ACC_W'(w_q);
					if (obs_count_q != CNT_MAX) begin
						obs_count_q <= obs_count_q + 1'b1;
					end
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					// no estimate unless the window closes with some weight
					if (!item_q.window_done || weight_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_RND;
					end
				end
				ST_RND: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_q <= in_item;
		end
		if (state_q == ST_DEC) begin
			w_q <= W_W'(item_q.span_count) * W_W'(item_q.span_count);
			res_q.estimate_ppb <= item_q.error_ppb;
			res_q.observations <= CNT_W'(1);
		end
		if (state_q == ST_MUL) begin
			prod_q <= PROD_W'(item_q.error_ppb * $signed({1'b0, w_q}));
		end
		if (state_q == ST_CHK) begin
			neg_q <= wacc_q[ACC_W-1];
			mag_q <= wacc_q[ACC_W-1] ? -wacc_q : wacc_q;
		end
		if (state_q == ST_DIV && div_stat.done) begin
			res_q.estimate_ppb <= est;
			res_q.observations <= obs_count_q;
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// divider finishes only while the sequencer waits on it
	`WFEE_ASSERT_NOW(a_div_done_in_div, clk, arst_n, div_stat.done, state_q == ST_DIV)
	// a clear item leaves all estimator state at zero
	`WFEE_ASSERT_NEXT(a_clear_zeroes, clk, arst_n,
		state_q == ST_DEC && item_q.opcode == OP_CLEAR,
		wacc_q == '0 && weight_q == '0 && obs_count_q == '0)
	// the observation count holds at its ceiling
	`WFEE_ASSERT_NEXT(a_count_sat, clk, arst_n,
		state_q == ST_ACC && obs_count_q == CNT_MAX, obs_count_q == CNT_MAX)

endmodule
